FILE: hdl/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

    localparam int MaxDigitsDefault = 3;
    localparam int QueueDepth       = 4;

    localparam logic [7:0] CharZero      = 8'h30;
    localparam logic [7:0] CharNine      = 8'h39;
    localparam logic [7:0] CharBackslash = 8'h5C;
    localparam logic [7:0] CharQuote     = 8'h22;
    localparam logic [7:0] CharApos      = 8'h27;
    localparam logic [7:0] CharQuestion  = 8'h3F;
    localparam logic [7:0] ByteMax       = 8'hFF;
    localparam logic [15:0] LengthMax    = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic        bad_escape;
        logic [15:0] out_length;
    } t_result;

    typedef struct packed {
        logic        hit;
        logic [7:0]  code;
    } t_esc;

    typedef struct packed {
        t_result     res;
        logic        emit;
        logic        to_esc;
        logic [15:0] count;
    } t_plain;

    function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
        sat_inc = (cnt == LengthMax) ? cnt : cnt + 16'd1;
    endfunction

    // Single-character escapes: control letters and the pass-through punctuation.
    function automatic t_esc esc_map(input logic [7:0] b);
        t_esc e;
        e.hit  = 1'b1;
        e.code = b;
        case (b)
            8'h61:   e.code = 8'd7;
            8'h62:   e.code = 8'd8;
            8'h66:   e.code = 8'd12;
            8'h6E:   e.code = 8'd10;
            8'h72:   e.code = 8'd13;
            8'h74:   e.code = 8'd9;
            8'h76:   e.code = 8'd11;
            CharQuote, CharApos, CharQuestion, CharBackslash: e.code = b;
            default: e.hit = 1'b0;
        endcase
        return e;
    endfunction

    // Handling of a byte outside any escape.
    function automatic t_plain plain_step(input logic [7:0] b, input logic [15:0] cnt);
        t_plain p;
        p.res    = '0;
        p.emit   = 1'b0;
        p.to_esc = 1'b0;
        p.count  = cnt;
        if (b == 8'd0) begin
            p.emit           = 1'b1;
            p.res.done_res   = 1'b1;
            p.res.out_length = cnt;
            p.count          = '0;
        end else if (b == CharBackslash) begin
            p.to_esc = 1'b1;
        end else begin
            p.emit           = 1'b1;
            p.count          = sat_inc(cnt);
            p.res.out_byte   = b;
            p.res.byte_valid = 1'b1;
            p.res.out_length = p.count;
        end
        return p;
    endfunction

endpackage

FILE: hdl/string_escape_decoder.sv
`timescale 1ns / 1ps

// Decodes an escaped string one item per clock unless stalled: each accepted
// byte is decoded in the same cycle and its zero, one or two results go into a
// four-entry queue that drives the output port, which shows them once the
// results ahead have been taken. A byte that closes a decimal escape and is
// itself a plain byte gives two results, so output moves at most one result per
// clock; the input stalls while fewer than two queue slots are free. Outside a
// dropped tail a zero byte ends a string with a done result of decoded length.
module string_escape_decoder #(
    parameter int MAX_DIGITS = sed_pkg::MaxDigitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_done_res,
    output logic        o_bad_escape,
    output logic [15:0] o_out_length
);
    import sed_pkg::*;

    localparam logic [1:0] ModeNormal = 2'd0;
    localparam logic [1:0] ModeEsc    = 2'd1;
    localparam logic [1:0] ModeDigits = 2'd2;
    localparam logic [1:0] ModeDrop   = 2'd3;

    localparam logic [1:0] MaxCnt = 2'(MAX_DIGITS);
    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    logic [1:0]  r_mode, n_mode;
    logic [9:0]  r_acc, n_acc;
    logic [1:0]  r_dcnt, n_dcnt;
    logic [15:0] r_bcnt, n_bcnt;

    t_result     r_queue [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic        in_fire, out_fire;
    logic [7:0]  b;
    logic        is_digit;
    logic [9:0]  digit_val;
    logic [9:0]  acc_mul;
    logic [1:0]  dcnt_inc;
    t_esc        esc;
    t_plain      p0, p1;
    t_result     res0, res1;
    logic [1:0]  nres;
    logic        do_fin;
    logic [9:0]  fin_v;
    logic        fin_bad;

    assign b         = i_in_byte;
    assign in_fire   = i_valid && !o_stall;
    assign out_fire  = o_valid && !i_stall;
    assign is_digit  = (b >= CharZero) && (b <= CharNine);
    assign digit_val = {2'b00, b - CharZero};
    assign acc_mul   = {r_acc[6:0], 3'b000} + {r_acc[8:0], 1'b0} + digit_val;
    assign dcnt_inc  = r_dcnt + 2'd1;
    assign esc       = esc_map(b);
    assign p0        = plain_step(b, r_bcnt);

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_dcnt  = r_dcnt;
        n_bcnt  = r_bcnt;
        res0    = '0;
        res1    = '0;
        nres    = 2'd0;
        do_fin  = 1'b0;
        fin_v   = r_acc;
        fin_bad = 1'b0;
        p1      = '0;
        case (r_mode)
            ModeNormal: begin
                n_bcnt = p0.count;
                res0   = p0.res;
                nres   = {1'b0, p0.emit};
                if (p0.to_esc) begin
                    n_mode = ModeEsc;
                end
            end
            ModeEsc: begin
                n_mode = ModeNormal;
                if (esc.hit) begin
                    n_bcnt          = sat_inc(r_bcnt);
                    res0.out_byte   = esc.code;
                    res0.byte_valid = 1'b1;
                    res0.out_length = n_bcnt;
                    nres            = 2'd1;
                end else if (is_digit) begin
                    n_acc  = digit_val;
                    n_dcnt = 2'd1;
                    n_mode = ModeDigits;
                    if (MaxCnt <= 2'd1) begin
                        do_fin = 1'b1;
                        fin_v  = digit_val;
                    end
                end else begin
                    fin_bad = 1'b1;
                end
            end
            ModeDigits: begin
                if (is_digit) begin
                    n_acc  = acc_mul;
                    n_dcnt = dcnt_inc;
                    if (dcnt_inc >= MaxCnt || dcnt_inc == 2'd0) begin
                        do_fin = 1'b1;
                        fin_v  = acc_mul;
                    end
                end else begin
                    do_fin = 1'b1;
                    fin_v  = r_acc;
                end
            end
            default: begin
                if (b == 8'd0) begin
                    n_mode = ModeNormal;
                end
            end
        endcase

        // Closing a decimal escape: either a byte or an out-of-range error.
        if (do_fin) begin
            n_acc  = '0;
            n_dcnt = '0;
            if (fin_v > {2'b00, ByteMax}) begin
                fin_bad = 1'b1;
            end else begin
                n_mode          = ModeNormal;
                n_bcnt          = sat_inc(r_bcnt);
                res0.out_byte   = fin_v[7:0];
                res0.byte_valid = 1'b1;
                res0.out_length = n_bcnt;
                nres            = 2'd1;
                // A non-digit that ended the run is then handled as a plain byte.
                if (!is_digit) begin
                    p1     = plain_step(b, n_bcnt);
                    n_bcnt = p1.count;
                    res1   = p1.res;
                    nres   = p1.emit ? 2'd2 : 2'd1;
                    if (p1.to_esc) begin
                        n_mode = ModeEsc;
                    end
                end
            end
        end

        if (fin_bad) begin
            res0            = '0;
            res0.done_res   = 1'b1;
            res0.bad_escape = 1'b1;
            res0.out_length = r_bcnt;
            nres            = 2'd1;
            n_bcnt          = '0;
            n_acc           = '0;
            n_dcnt          = '0;
            n_mode          = (b == 8'd0) ? ModeNormal : ModeDrop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeNormal;
            r_acc  <= '0;
            r_dcnt <= '0;
            r_bcnt <= '0;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_dcnt <= n_dcnt;
            r_bcnt <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(nres);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            r_count <= r_count + (in_fire ? CntW'(nres) : CntW'(0))
                               - (out_fire ? CntW'(1) : CntW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && nres != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_fire && nres == 2'd2) begin
            r_queue[r_wr_ptr + PtrW'(1)] <= res1;
        end
    end

    assign o_stall      = r_count > CntW'(QueueDepth - 2);
    assign o_valid      = r_count != '0;
    assign o_out_byte   = r_queue[r_rd_ptr].out_byte;
    assign o_byte_valid = r_queue[r_rd_ptr].byte_valid;
    assign o_done_res   = r_queue[r_rd_ptr].done_res;
    assign o_bad_escape = r_queue[r_rd_ptr].bad_escape;
    assign o_out_length = r_queue[r_rd_ptr].out_length;

endmodule

FILE: verif/tb_string_escape_decoder.sv
`timescale 1ns / 1ps

module tb_string_escape_decoder;
    import sed_pkg::*;

    localparam int MaxDigits   = MaxDigitsDefault;
    localparam int IdlePct     = 37;
    localparam int RandomItems = 950;
    localparam int HoldCycles  = 150;
    localparam int StuckLimit  = 4000;
    localparam int DrainCycles = 20;
    localparam int ShownErrors = 10;

    typedef enum logic [1:0] {
        ST_PLAIN  = 2'd0,
        ST_ESC    = 2'd1,
        ST_DIGITS = 2'd2,
        ST_DROP   = 2'd3
    } t_dec_mode;

    typedef struct packed {
        logic [7:0] src;
        logic       typed;
        t_result    want;
    } t_dir_row;

    localparam int DirRows = 26;
    localparam t_dir_row DirTab [DirRows] = '{
        '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 16'd0}},
        '{8'h01, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b0, 16'd1}},
        '{8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 16'd2}},
        '{CharBackslash, 1'b0, '0},
        '{"n", 1'b0, '0},
        '{CharBackslash, 1'b0, '0},
        '{CharQuestion, 1'b0, '0},
        '{CharBackslash, 1'b0, '0},
        '{"2", 1'b0, '0},
        '{"5", 1'b0, '0},
        '{"5", 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 16'd5}},
        '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 16'd5}},
        // A decimal value above the byte range fails and drops the rest of the string.
        '{CharBackslash, 1'b0, '0},
        '{"2", 1'b0, '0},
        '{"5", 1'b0, '0},
        '{"6", 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 16'd0}},
        '{"A", 1'b0, '0},
        '{8'h00, 1'b0, '0},
        // A short digit run closed by a plain byte gives two results at once.
        '{CharBackslash, 1'b0, '0},
        '{"7", 1'b0, '0},
        '{"A", 1'b0, '0},
        '{CharBackslash, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 16'd2}},
        '{CharBackslash, 1'b0, '0},
        '{"z", 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 16'd0}},
        '{8'h00, 1'b0, '0}
    };

    localparam logic [7:0] EscLetters [7] = '{"a", "b", "f", "n", "r", "t", "v"};
    localparam logic [7:0] EscPunct [4] = '{CharQuote, CharApos, CharQuestion, CharBackslash};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_done_res;
    logic        o_bad_escape;
    logic [15:0] o_out_length;

    string_escape_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_done_res   (o_done_res),
        .o_bad_escape (o_bad_escape),
        .o_out_length (o_out_length)
    );

    always #1 i_clk = ~i_clk;

    // Decoder state as the predictor sees it.
    t_dec_mode   p_mode  = ST_PLAIN;
    logic [9:0]  p_accum = '0;
    logic [1:0]  p_ndig  = '0;
    logic [15:0] p_count = '0;

    t_result     step_res[$];
    t_result     decoded_q[$];
    t_result     got;
    t_result     want;

    int          idle_pct = IdlePct;
    bit          hold_req = 1'b0;
    bit          cur_typed = 1'b0;
    t_result     cur_want = '0;

    int          in_accepted = 0;
    int          live_items = 0;
    int          results_seen = 0;
    int          strings_done = 0;
    int          strings_bad = 0;
    int          longest = 0;
    int          mismatches = 0;
    int          stuck_cycles = 0;

    task automatic put_res(input logic [7:0] b, input logic v, input logic d, input logic bad);
        t_result r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.done_res   = d;
        r.bad_escape = bad;
        r.out_length = p_count;
        step_res.push_back(r);
    endtask

    task automatic emit_char(input logic [7:0] b);
        if (p_count != LengthMax) p_count = p_count + 16'd1;
        put_res(b, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic emit_err(input logic [7:0] b);
        put_res(8'h00, 1'b0, 1'b1, 1'b1);
        p_count = '0;
        p_accum = '0;
        p_ndig  = '0;
        p_mode  = (b == 8'h00) ? ST_PLAIN : ST_DROP;
    endtask

    task automatic plain_char(input logic [7:0] b);
        if (b == 8'h00) begin
            put_res(8'h00, 1'b0, 1'b1, 1'b0);
            p_count = '0;
        end else if (b == CharBackslash) begin
            p_mode = ST_ESC;
        end else begin
            emit_char(b);
        end
    endtask

    task automatic close_digits(input logic [7:0] b, output bit failed);
        logic [9:0] v;
        v       = p_accum;
        p_accum = '0;
        p_ndig  = '0;
        if (v > {2'b00, ByteMax}) begin
            failed = 1'b1;
            emit_err(b);
        end else begin
            failed = 1'b0;
            p_mode = ST_PLAIN;
            emit_char(v[7:0]);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        bit failed;
        bit digit;
        digit = (b >= CharZero) && (b <= CharNine);
        case (p_mode)
            ST_PLAIN: plain_char(b);
            ST_ESC: begin
                p_mode = ST_PLAIN;
                case (b)
                    "a": emit_char(8'd7);
                    "b": emit_char(8'd8);
                    "f": emit_char(8'd12);
                    "n": emit_char(8'd10);
                    "r": emit_char(8'd13);
                    "t": emit_char(8'd9);
                    "v": emit_char(8'd11);
                    CharQuote, CharApos, CharQuestion, CharBackslash: emit_char(b);
                    default: begin
                        if (digit) begin
                            p_accum = 10'(b - CharZero);
                            p_ndig  = 2'd1;
                            p_mode  = ST_DIGITS;
                            if (p_ndig >= MaxDigits) close_digits(b, failed);
                        end else begin
                            emit_err(b);
                        end
                    end
                endcase
            end
            ST_DIGITS: begin
                if (digit) begin
                    p_accum = p_accum * 10'd10 + 10'(b - CharZero);
                    p_ndig  = p_ndig + 2'd1;
                    if (p_ndig >= MaxDigits || p_ndig == 2'd0) close_digits(b, failed);
                end else begin
                    close_digits(b, failed);
                    if (!failed) plain_char(b);
                end
            end
            default: begin
                if (b == 8'h00) p_mode = ST_PLAIN;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input t_result exp_r, input t_result act_r);
        mismatches++;
        if (mismatches <= ShownErrors) begin
            $display("MISMATCH %s: expected byte %02h valid %0b done %0b bad %0b len %0d,",
                     what, exp_r.out_byte, exp_r.byte_valid, exp_r.done_res,
                     exp_r.bad_escape, exp_r.out_length);
            $display("    got byte %02h valid %0b done %0b bad %0b len %0d",
                     act_r.out_byte, act_r.byte_valid, act_r.done_res,
                     act_r.bad_escape, act_r.out_length);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stuck_cycles = stuck_cycles + 1;
            if (o_valid && !i_stall) begin
                stuck_cycles = 0;
                results_seen++;
                got = '{o_out_byte, o_byte_valid, o_done_res, o_bad_escape, o_out_length};
                if (got.done_res === 1'b1) strings_done++;
                if (got.bad_escape === 1'b1) strings_bad++;
                if (got.out_length > longest) longest = got.out_length;
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.done_res !== want.done_res || got.bad_escape !== want.bad_escape ||
                        got.out_length !== want.out_length)
                        report_mismatch("wrong result", want, got);
                end
            end
            if (i_valid && !o_stall) begin
                stuck_cycles = 0;
                in_accepted++;
                if (p_mode != ST_DROP) live_items++;
                step_res.delete();
                decode_byte(i_in_byte);
                if (cur_typed) begin
                    decoded_q.push_back(cur_want);
                end else begin
                    foreach (step_res[k]) decoded_q.push_back(step_res[k]);
                end
            end
            if (stuck_cycles >= StuckLimit) begin
                $display("Timeout: no handshake for %0d cycles", StuckLimit);
                $display("string_escape_decoder verification failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HoldCycles) @(negedge i_clk);
            end
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic send_item(input logic [7:0] b, input bit typed, input t_result exp_r);
        int seen;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_typed = typed;
        cur_want  = exp_r;
        i_valid   <= 1'b1;
        i_in_byte <= b;
        seen = in_accepted;
        do @(negedge i_clk); while (in_accepted == seen);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0, '0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (decoded_q.size() != 0);
    endtask

    // One escape-level token. In legal-only mode no token can end the string early.
    task automatic send_token(input bit legal_only);
        int         kind;
        int         nd;
        logic [7:0] c;
        kind = $urandom_range(99);
        if (kind < 45) begin
            c = 8'($urandom_range(255, 1));
            if (c == CharBackslash) c = c ^ 8'h01;
            send_byte(c);
        end else if (kind < 62) begin
            send_byte(CharBackslash);
            send_byte(EscLetters[$urandom_range(6)]);
        end else if (kind < 72) begin
            send_byte(CharBackslash);
            send_byte(EscPunct[$urandom_range(3)]);
        end else if (kind < 92 || legal_only) begin
            nd = legal_only ? 3 : $urandom_range(3, 1);
            send_byte(CharBackslash);
            for (int i = 0; i < nd; i++) begin
                c = 8'($urandom_range(9));
                if (i == 0 && nd == 3 && (legal_only || $urandom_range(3) != 0))
                    c = 8'($urandom_range(legal_only ? 1 : 2));
                send_byte(CharZero + c);
            end
        end else begin
            send_byte(CharBackslash);
            send_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int  kind;
        int  n;
        int  start_items;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_byte = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DirTab[r]) send_item(DirTab[r].src, DirTab[r].typed, DirTab[r].want);

        start_items = in_accepted;
        while (in_accepted - start_items < RandomItems) begin
            n = in_accepted - start_items;
            idle_pct = (n >= 400 && n < 550) ? 0 : IdlePct;
            if (n >= 300 && !hold_done) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (n >= 650 && !pause_done) begin
                pause_done = 1'b1;
                wait_drained();
            end
            kind = $urandom_range(99);
            if (kind < 80) begin
                repeat ($urandom_range(8)) send_token(1'b0);
                send_byte(8'h00);
            end else if (kind < 90) begin
                repeat ($urandom_range(12, 1)) begin
                    if ($urandom_range(5) == 0) send_byte(CharBackslash);
                    else send_byte(8'($urandom_range(255)));
                end
            end else begin
                repeat ($urandom_range(4)) send_token(1'b0);
                send_byte(CharBackslash);
                if ($urandom_range(1) == 0) send_byte(CharZero + 8'($urandom_range(9)));
                send_byte(8'h00);
            end
        end
        send_byte(8'h00);

        wait_drained();
        repeat (DrainCycles) @(negedge i_clk);

        $display("Run fed %0d source items (%0d outside dropped tails) and checked %0d results.",
                 in_accepted, live_items, results_seen);
        $display("%0d strings closed, %0d on a bad escape; largest length seen %0d.",
                 strings_done, strings_bad, longest);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("string_escape_decoder verification clean");
        end else begin
            $display("string_escape_decoder verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/sed_pkg.sv
hdl/string_escape_decoder.sv
verif/tb_string_escape_decoder.sv
